[hw/rtl/rlewl_pkg.sv]
// shared types and constants of the run-length encoder with literal runs
package rlewl_pkg;

	// run length and literal count width, covers the largest chunk size of 78
	localparam int LEN_W = 7;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] RUN_MARK   = 8'd127;
	localparam logic [7:0] COUNT_BIAS = 8'd48;

	localparam logic [4:0] THR_RESET = 5'd5;

	// register index taken from paddr[2]
	localparam logic REG_RUN_THRESHOLD = 1'b0;

	// one close-run job for the back end; len of zero means no run to close
	typedef struct packed {
		logic [7:0]       val;
		logic [LEN_W-1:0] len;
		logic             flush;
		logic             item_end;
		logic             strm_last;
	} cmd_t;

endpackage

[hw/rtl/rlewl_queue.sv]
// two-entry command queue between the front and back ends
module rlewl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rlewl_pkg::cmd_t   push_cmd,
	output logic              full,
	output logic              cmd_valid,
	output rlewl_pkg::cmd_t   cmd,
	input  logic              pop
);

	localparam int PTR_W = $clog2(rlewl_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(rlewl_pkg::QUEUE_DEPTH + 1);

	rlewl_pkg::cmd_t   entry_q [rlewl_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  fill_q;
	logic              do_push;
	logic              do_pop;

	assign full      = fill_q == CNT_W'(rlewl_pkg::QUEUE_DEPTH);
	assign cmd_valid = fill_q != '0;
	assign cmd       = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop) fill_q <= fill_q + CNT_W'(1);
			else if (do_pop && !do_push) fill_q <= fill_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

[hw/rtl/rlewl_front.sv]
// front end: tracks the open run and turns input beats into close-run commands
module rlewl_front #(
	parameter int CHUNK_SIZE = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              data_valid,
	output logic              data_stall,
	input  logic [7:0]        data_byte,
	input  logic              stream_last,
	output logic              push,
	output rlewl_pkg::cmd_t   push_cmd,
	input  logic              q_full
);

	localparam int LW = rlewl_pkg::LEN_W;
	localparam logic [LW-1:0] CHUNK_LEN = LW'(CHUNK_SIZE);

	logic [7:0]       run_val_q;
	logic [LW-1:0]    run_len_q;
	logic             pend_v_q;
	rlewl_pkg::cmd_t  pend_q;
	logic             accept;
	logic             extend;
	rlewl_pkg::cmd_t  new_run_cmd;

	assign data_stall = pend_v_q || q_full;
	assign accept     = data_valid && !data_stall;
	assign extend     = (run_len_q != '0) && (data_byte == run_val_q) && (run_len_q < CHUNK_LEN);

	// final beat opening a fresh run: close it at once and flush
	assign new_run_cmd = '{val: data_byte, len: LW'(1), flush: 1'b1, item_end: 1'b1,
		strm_last: 1'b1};

	always_comb begin
		push     = 1'b0;
		push_cmd = '0;
		if (pend_v_q) begin
			push     = !q_full;
			push_cmd = pend_q;
		end else if (accept) begin
			if (extend && stream_last) begin
				push     = 1'b1;
				push_cmd = '{val: run_val_q, len: run_len_q + LW'(1), flush: 1'b1,
					item_end: 1'b1, strm_last: 1'b1};
			end else if (!extend && run_len_q != '0) begin
				push     = 1'b1;
				push_cmd = '{val: run_val_q, len: run_len_q, flush: 1'b0,
					item_end: !stream_last, strm_last: 1'b0};
			end else if (!extend && stream_last) begin
				push     = 1'b1;
				push_cmd = new_run_cmd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_val_q <= '0;
			run_len_q <= '0;
			pend_v_q  <= 1'b0;
		end else begin
			if (accept) begin
				if (stream_last) begin
					run_val_q <= '0;
					run_len_q <= '0;
				end else if (extend) begin
					run_len_q <= run_len_q + LW'(1);
				end else begin
					run_val_q <= data_byte;
					run_len_q <= LW'(1);
				end
			end
			if (accept && stream_last && !extend && run_len_q != '0) pend_v_q <= 1'b1;
			else if (pend_v_q && !q_full) pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) pend_q <= new_run_cmd;
	end

endmodule

[hw/rtl/rlewl_back.sv]
// back end: literal buffer, marker triples and the output register
module rlewl_back #(
	parameter int CHUNK_SIZE = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [4:0]        thr,
	input  logic              cmd_valid,
	input  rlewl_pkg::cmd_t   cmd,
	output logic              cmd_pop,
	output logic              code_valid,
	input  logic              code_stall,
	output logic [7:0]        code_byte,
	output logic              last_of_item,
	output logic              stream_done
);

	localparam int LW    = rlewl_pkg::LEN_W;
	localparam int IDX_W = $clog2(CHUNK_SIZE);
	localparam logic [LW-1:0] CHUNK_LEN = LW'(CHUNK_SIZE);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RUN  = 4'd1;
	localparam logic [3:0] ST_ADD  = 4'd2;
	localparam logic [3:0] ST_POST = 4'd3;
	localparam logic [3:0] ST_FIN  = 4'd4;
	localparam logic [3:0] ST_FHDR = 4'd5;
	localparam logic [3:0] ST_FDAT = 4'd6;
	localparam logic [3:0] ST_MARK = 4'd7;
	localparam logic [3:0] ST_MVAL = 4'd8;
	localparam logic [3:0] ST_MLEN = 4'd9;

	logic [3:0]       st_q;
	logic [3:0]       ret_q;
	logic [7:0]       val_q;
	logic [LW-1:0]    len_q;
	logic [LW-1:0]    rem_q;
	logic             flush_q;
	logic             end_q;
	logic             last_q;
	logic [LW-1:0]    cnt_q;
	logic [LW-1:0]    idx_q;
	logic [7:0]       store [CHUNK_SIZE];
	logic [7:0]       rdata_q;
	logic             hold_v_q;
	logic [7:0]       hold_q;
	logic             out_v_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic             out_done_q;

	logic             out_free;
	logic             can_emit;
	logic             emit_en;
	logic [7:0]       emit_byte;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             tag_en;
	logic             fin_go;
	logic [LW-1:0]    idx_nxt;
	logic [LW-1:0]    cnt_nxt;

	assign out_free = !out_v_q || !code_stall;
	assign can_emit = !hold_v_q || out_free;
	assign idx_nxt  = idx_q + LW'(1);
	assign cnt_nxt  = cnt_q + LW'(1);
	assign fin_go   = !(end_q && hold_v_q) || out_free;
	assign cmd_pop  = (st_q == ST_IDLE) && cmd_valid;

	always_comb begin
		emit_en   = 1'b0;
		emit_byte = '0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		tag_en    = 1'b0;
		case (st_q)
			ST_FHDR: begin
				emit_en   = can_emit;
				emit_byte = 8'(cnt_q) + rlewl_pkg::COUNT_BIAS;
				rd_en     = can_emit;
			end
			ST_FDAT: begin
				emit_en   = can_emit;
				emit_byte = rdata_q;
				rd_en     = can_emit && (idx_nxt < cnt_q);
				rd_addr   = idx_nxt[IDX_W-1:0];
			end
			ST_MARK: begin
				emit_en   = can_emit;
				emit_byte = rlewl_pkg::RUN_MARK;
			end
			ST_MVAL: begin
				emit_en   = can_emit;
				emit_byte = val_q;
			end
			ST_MLEN: begin
				emit_en   = can_emit;
				emit_byte = 8'(len_q) + rlewl_pkg::COUNT_BIAS;
			end
			ST_FIN: begin
				tag_en = end_q && hold_v_q && out_free;
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (cmd_valid) st_q <= ST_RUN;
				end
				ST_RUN: begin
					if (rem_q == '0) st_q <= ST_POST;
					else if (rem_q < LW'(thr)) st_q <= ST_ADD;
					else if (cnt_q != '0) st_q <= ST_FHDR;
					else st_q <= ST_MARK;
				end
				ST_ADD: begin
					cnt_q <= cnt_nxt;
					if (cnt_nxt == CHUNK_LEN) st_q <= ST_FHDR;
					else if (rem_q == LW'(1)) st_q <= ST_POST;
				end
				ST_POST: begin
					if (flush_q && cnt_q != '0) st_q <= ST_FHDR;
					else st_q <= ST_FIN;
				end
				ST_FHDR: begin
					if (can_emit) st_q <= ST_FDAT;
				end
				ST_FDAT: begin
					if (can_emit && idx_nxt == cnt_q) begin
						cnt_q <= '0;
						st_q  <= ret_q;
					end
				end
				ST_MARK: begin
					if (can_emit) st_q <= ST_MVAL;
				end
				ST_MVAL: begin
					if (can_emit) st_q <= ST_MLEN;
				end
				ST_MLEN: begin
					if (can_emit) st_q <= ST_POST;
				end
				ST_FIN: begin
					if (fin_go) st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command fields, flush return point and read index
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			val_q   <= cmd.val;
			len_q   <= cmd.len;
			rem_q   <= cmd.len;
			flush_q <= cmd.flush;
			end_q   <= cmd.item_end;
			last_q  <= cmd.strm_last;
		end
		if (st_q == ST_RUN) ret_q <= ST_MARK;
		if (st_q == ST_POST) ret_q <= ST_FIN;
		if (st_q == ST_ADD) begin
			rem_q <= rem_q - LW'(1);
			ret_q <= (rem_q == LW'(1)) ? ST_POST : ST_ADD;
		end
		if (st_q == ST_FHDR) idx_q <= '0;
		else if (st_q == ST_FDAT && can_emit) idx_q <= idx_nxt;
	end

	// literal buffer, read data registered
	always_ff @(posedge clk) begin
		if (st_q == ST_ADD) store[cnt_q[IDX_W-1:0]] <= val_q;
		if (rd_en) rdata_q <= store[rd_addr];
	end

	// one byte is held back until it is known whether it closes the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (emit_en) hold_v_q <= 1'b1;
			else if (tag_en) hold_v_q <= 1'b0;
			if ((emit_en && hold_v_q) || tag_en) out_v_q <= 1'b1;
			else if (!code_stall) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) hold_q <= emit_byte;
		if ((emit_en && hold_v_q) || tag_en) begin
			out_byte_q <= hold_q;
			out_last_q <= tag_en;
			out_done_q <= tag_en && last_q;
		end
	end

	assign code_valid   = out_v_q;
	assign code_byte    = out_byte_q;
	assign last_of_item = out_last_q;
	assign stream_done  = out_done_q;

endmodule

[hw/rtl/run_length_encoder_with_literals.sv]
// top level of the run-length encoder with literal runs
//
//  channel  | beat carries                          | handshake
//  ---------+---------------------------------------+------------------------
//  data     | data_byte, stream_last                | data_valid / data_stall
//  code     | code_byte, last_of_item, stream_done  | code_valid / code_stall
//  config   | run_threshold at byte address 0       | apb, pready tied high
//
// a byte that extends or opens a run is taken unless the queue is full or a command waits; a byte
// that closes a run costs back-end time for each literal added or each byte sent, plus command
// handling; the back-end sequencer and its literal buffer set the pace
// the two-entry command queue lets the front keep taking bytes while the back is busy
// reset clears runs, literal count, queue and output; run_threshold returns to 5
// code_stall holds the output register, a further byte waits in a hold stage
module run_length_encoder_with_literals #(
	parameter int CHUNK_SIZE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	input  logic        stream_last,
	output logic        code_valid,
	input  logic        code_stall,
	output logic [7:0]  code_byte,
	output logic        last_of_item,
	output logic        stream_done,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [4:0]       thr_q;
	logic             push;
	rlewl_pkg::cmd_t  push_cmd;
	logic             q_full;
	logic             cmd_valid;
	rlewl_pkg::cmd_t  cmd;
	logic             cmd_pop;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == rlewl_pkg::REG_RUN_THRESHOLD) ? 32'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= rlewl_pkg::THR_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == rlewl_pkg::REG_RUN_THRESHOLD) begin
			thr_q <= pwdata[4:0];
		end
	end

	rlewl_front #(.CHUNK_SIZE(CHUNK_SIZE)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data_byte  (data_byte),
		.stream_last(stream_last),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_full     (q_full)
	);

	rlewl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.pop      (cmd_pop)
	);

	rlewl_back #(.CHUNK_SIZE(CHUNK_SIZE)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.thr         (thr_q),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.code_valid  (code_valid),
		.code_stall  (code_stall),
		.code_byte   (code_byte),
		.last_of_item(last_of_item),
		.stream_done (stream_done)
	);

endmodule

[hw/rtl/rlewl_checker.sv]
// port-level checks of the encoder, bound to the top level
module rlewl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        code_valid,
	input logic        code_stall,
	input logic [7:0]  code_byte,
	input logic        last_of_item,
	input logic        stream_done,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	// the end of the stream always closes an item
	a_done_is_item_end: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && stream_done |-> last_of_item)
		else $error("stream_done without last_of_item");

	a_code_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_stall |=> code_valid && $stable(code_byte)
			&& $stable(last_of_item) && $stable(stream_done))
		else $error("stalled code beat changed");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	// a threshold write reads back on the next cycle
	a_thr_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == rlewl_pkg::REG_RUN_THRESHOLD
			|=> paddr[2] != rlewl_pkg::REG_RUN_THRESHOLD
			|| prdata[4:0] == $past(pwdata[4:0]))
		else $error("threshold readback mismatch");

	a_prdata_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:5] == '0)
		else $error("unused prdata bits set");

endmodule

bind run_length_encoder_with_literals rlewl_checker u_rlewl_checker (.*);

[dv/run_length_encoder_with_literals_tb.sv]
// testbench for the run-length encoder with literal runs
`timescale 1ns / 100ps

module run_length_encoder_with_literals_tb;

	localparam int CHUNK = 16;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} raw_beat_t;

	typedef struct packed {
		logic [7:0] code;
		logic       item_end;
		logic       done;
	} code_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        data_valid = 1'b0;
	logic        data_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        stream_last = 1'b0;
	logic        code_valid;
	logic        code_stall = 1'b0;
	logic [7:0]  code_byte;
	logic        last_of_item;
	logic        stream_done;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	run_length_encoder_with_literals #(.CHUNK_SIZE(CHUNK)) dut (
		.clk(clk), .arst_n(arst_n),
		.data_valid(data_valid), .data_stall(data_stall),
		.data_byte(data_byte), .stream_last(stream_last),
		.code_valid(code_valid), .code_stall(code_stall),
		.code_byte(code_byte), .last_of_item(last_of_item), .stream_done(stream_done),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// encoder shadow state
	logic [4:0] thr_shadow = rlewl_pkg::THR_RESET;
	logic [7:0] run_val = 8'd0;
	int         run_len = 0;
	logic [7:0] lit_buf [CHUNK];
	int         lit_cnt = 0;

	raw_beat_t  pending_bytes [$];
	code_beat_t expected_codes [$];
	code_beat_t caused [$];

	int         err_cnt = 0;
	bit         idle_on = 1'b1;
	bit         hold_go = 1'b0;
	logic       rx_hold = 1'b0;
	int         tx_gap = 0;
	int         rx_gap = 0;
	raw_beat_t  next_beat;
	code_beat_t want;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic note_error(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic void put_code(input logic [7:0] b);
		code_beat_t c;
		c.code = b;
		c.item_end = 1'b0;
		c.done = 1'b0;
		caused.push_back(c);
	endfunction

	function automatic void flush_literals();
		if (lit_cnt == 0)
			return;
		put_code(8'(lit_cnt) + rlewl_pkg::COUNT_BIAS);
		for (int i = 0; i < lit_cnt; i++)
			put_code(lit_buf[i]);
		lit_cnt = 0;
	endfunction

	function automatic void close_run();
		if (run_len == 0)
			return;
		if (run_len < int'(thr_shadow)) begin
			for (int i = 0; i < run_len; i++) begin
				lit_buf[lit_cnt] = run_val;
				lit_cnt++;
				if (lit_cnt >= CHUNK)
					flush_literals();
			end
		end else begin
			flush_literals();
			put_code(rlewl_pkg::RUN_MARK);
			put_code(run_val);
			put_code(8'(run_len) + rlewl_pkg::COUNT_BIAS);
		end
		run_len = 0;
	endfunction

	// works out the code beats that one raw byte causes
	function automatic void encode_byte(input logic [7:0] b, input logic last);
		code_beat_t c;
		caused.delete();
		if (run_len != 0 && b == run_val && run_len < CHUNK) begin
			run_len++;
		end else begin
			close_run();
			run_val = b;
			run_len = 1;
		end
		if (last) begin
			close_run();
			flush_literals();
			run_val = 8'd0;
		end
		if (caused.size() != 0) begin
			c = caused[caused.size() - 1];
			c.item_end = 1'b1;
			c.done = last;
			caused[caused.size() - 1] = c;
		end
		foreach (caused[i])
			expected_codes.push_back(caused[i]);
	endfunction

	// raw byte driver
	always @(posedge clk) begin
		if (!arst_n) begin
			data_valid <= 1'b0;
		end else begin
			if (data_valid && !data_stall)
				encode_byte(data_byte, stream_last);
			if (!(data_valid && data_stall)) begin
				if (tx_gap > 0) begin
					tx_gap--;
					data_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					next_beat = pending_bytes.pop_front();
					data_byte <= next_beat.b;
					stream_last <= next_beat.last;
					data_valid <= 1'b1;
					if (idle_on && $urandom_range(0, 7) == 0)
						tx_gap = $urandom_range(1, 19);
				end else begin
					data_valid <= 1'b0;
				end
			end
		end
	end

	// code beat monitor and receiver stall
	always @(posedge clk) begin
		if (!arst_n) begin
			code_stall <= 1'b0;
		end else begin
			if (code_valid && !code_stall) begin
				if (expected_codes.size() == 0) begin
					note_error($sformatf("unexpected code beat %h", code_byte));
				end else begin
					want = expected_codes.pop_front();
					if (code_byte !== want.code)
						note_error($sformatf("code_byte %h, want %h", code_byte, want.code));
					if (last_of_item !== want.item_end)
						note_error($sformatf("last_of_item %b, want %b",
							last_of_item, want.item_end));
					if (stream_done !== want.done)
						note_error($sformatf("stream_done %b, want %b",
							stream_done, want.done));
				end
			end
			if (rx_gap > 0)
				rx_gap--;
			else if (idle_on && $urandom_range(0, 9) == 0)
				rx_gap = $urandom_range(1, 19);
			code_stall <= rx_hold || (rx_gap != 0);
		end
	end

	// long receiver hold-off so the block backs up onto its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#20000000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic push_byte(input logic [7:0] b, input logic last);
		raw_beat_t r;
		r.b = b;
		r.last = last;
		pending_bytes.push_back(r);
	endtask

	task automatic write_threshold(input logic [4:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {rlewl_pkg::REG_RUN_THRESHOLD, 2'b00};
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		thr_shadow = v;
	endtask

	// sender pauses until every code beat is back, then lets the back end settle
	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (pending_bytes.size() != 0 || data_valid || expected_codes.size() != 0);
		repeat (60) @(posedge clk);
	endtask

	// whole streams of runs with random lengths and values
	task automatic add_streams(input int n);
		int left;
		int len;
		int k;
		int rl;
		int mode;
		logic [7:0] v;
		left = n;
		while (left > 0) begin
			len = $urandom_range(1, 30);
			if (len > left)
				len = left;
			k = 0;
			while (k < len) begin
				mode = $urandom_range(0, 9);
				if (mode < 6)
					rl = $urandom_range(1, 2);
				else if (mode < 8)
					rl = $urandom_range(3, 8);
				else if (mode == 8)
					rl = $urandom_range(12, 20);
				else
					rl = 33;
				if ($urandom_range(0, 3) == 0)
					v = {$urandom_range(0, 1) ? 8'hff : 8'h00} ^ 8'($urandom_range(0, 1));
				else
					v = 8'($urandom_range(0, 255));
				for (int j = 0; j < rl && k < len; j++) begin
					push_byte(v, k == len - 1);
					k++;
				end
			end
			left -= len;
		end
	endtask

	initial begin
		int thr_list [$];
		thr_list = '{2, 16, 1, 17, 3, 8, 5};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte stream, then a run past the chunk size
		push_byte(8'h00, 1'b1);
		repeat (17) push_byte(8'hff, 1'b0);
		push_byte(8'h80, 1'b1);
		wait_drained();

		// threshold zero: every run becomes a marker triple
		write_threshold(5'd0);
		push_byte(8'h55, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(8'haa, 1'b1);
		wait_drained();

		// threshold above the chunk size: every run becomes literals
		write_threshold(5'd31);
		push_byte(8'h01, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h7f, 1'b1);
		wait_drained();

		foreach (thr_list[i]) begin
			write_threshold(5'(thr_list[i]));
			idle_on = (i % 3) != 2;
			add_streams(20);
			wait_drained();
		end

		// back pressure: sender keeps offering while the receiver holds off
		write_threshold(5'd3);
		idle_on = 1'b0;
		hold_go = 1'b1;
		add_streams(40);
		wait_drained();

		write_threshold(5'd4);
		add_streams(20);
		wait_drained();

		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
hw/rtl/rlewl_pkg.sv
hw/rtl/rlewl_queue.sv
hw/rtl/rlewl_front.sv
hw/rtl/rlewl_back.sv
hw/rtl/run_length_encoder_with_literals.sv
hw/rtl/rlewl_checker.sv
dv/run_length_encoder_with_literals_tb.sv
